[rtl/lsp_pkg.sv]
package lsp_pkg;

  localparam logic [2:0] MODE_SLEEP     = 3'd0;
  localparam logic [2:0] MODE_BLINK_MIN = 3'd1;
  localparam logic [2:0] MODE_BLINK_MAX = 3'd3;
  localparam logic [2:0] MODE_SINE_FAST = 3'd4;
  localparam logic [2:0] MODE_SINE_SLOW = 3'd5;

  localparam logic [8:0] STEP_FAST  = 9'd5;
  localparam logic [8:0] STEP_SLOW  = 9'd1;
  localparam logic [8:0] PHASE_LAST = 9'd359;
  localparam logic [8:0] PHASE_TURN = 9'd360;
  localparam logic [8:0] DEG_90     = 9'd90;
  localparam logic [8:0] DEG_180    = 9'd180;
  localparam logic [8:0] DEG_270    = 9'd270;

  localparam int TABLE_FRAC = 16;

  typedef enum logic [2:0] {
    REG_RED_CHARGING   = 3'd0,
    REG_RED_BATTERY    = 3'd1,
    REG_GREEN_CHARGING = 3'd2,
    REG_GREEN_BATTERY  = 3'd3,
    REG_PULSE_ON       = 3'd4,
    REG_PULSE_OFF      = 3'd5,
    REG_PAUSE          = 3'd6,
    REG_TICK           = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0] red_charging_duty;
    logic [15:0] red_battery_duty;
    logic [15:0] green_charging_duty;
    logic [15:0] green_battery_duty;
    logic [15:0] pulse_on_ms;
    logic [15:0] pulse_off_ms;
    logic [15:0] pause_ms;
    logic [7:0]  tick_ms;
  } cfg_t;

  // first pipeline stage contents
  typedef struct packed {
    logic        valid;
    logic        is_sine;
    logic [15:0] red_val;
    logic [15:0] green_val;
    logic [14:0] half;
    logic [8:0]  deg;
  } stage1_t;

  // round(65536 * sin(k deg)), k = 0..90
  function automatic logic [16:0] quarter_sine(input logic [6:0] k);
    logic [16:0] v;
    unique case (k)
      7'd0:  v = 17'd0;     7'd1:  v = 17'd1144;  7'd2:  v = 17'd2287;
      7'd3:  v = 17'd3430;  7'd4:  v = 17'd4572;  7'd5:  v = 17'd5712;
      7'd6:  v = 17'd6850;  7'd7:  v = 17'd7987;  7'd8:  v = 17'd9121;
      7'd9:  v = 17'd10252; 7'd10: v = 17'd11380; 7'd11: v = 17'd12505;
      7'd12: v = 17'd13626; 7'd13: v = 17'd14742; 7'd14: v = 17'd15855;
      7'd15: v = 17'd16962; 7'd16: v = 17'd18064; 7'd17: v = 17'd19161;
      7'd18: v = 17'd20252; 7'd19: v = 17'd21336; 7'd20: v = 17'd22415;
      7'd21: v = 17'd23486; 7'd22: v = 17'd24550; 7'd23: v = 17'd25607;
      7'd24: v = 17'd26656; 7'd25: v = 17'd27697; 7'd26: v = 17'd28729;
      7'd27: v = 17'd29753; 7'd28: v = 17'd30767; 7'd29: v = 17'd31772;
      7'd30: v = 17'd32768; 7'd31: v = 17'd33754; 7'd32: v = 17'd34729;
      7'd33: v = 17'd35693; 7'd34: v = 17'd36647; 7'd35: v = 17'd37590;
      7'd36: v = 17'd38521; 7'd37: v = 17'd39441; 7'd38: v = 17'd40348;
      7'd39: v = 17'd41243; 7'd40: v = 17'd42126; 7'd41: v = 17'd42995;
      7'd42: v = 17'd43852; 7'd43: v = 17'd44695; 7'd44: v = 17'd45525;
      7'd45: v = 17'd46341; 7'd46: v = 17'd47143; 7'd47: v = 17'd47930;
      7'd48: v = 17'd48703; 7'd49: v = 17'd49461; 7'd50: v = 17'd50203;
      7'd51: v = 17'd50931; 7'd52: v = 17'd51643; 7'd53: v = 17'd52339;
      7'd54: v = 17'd53020; 7'd55: v = 17'd53684; 7'd56: v = 17'd54332;
      7'd57: v = 17'd54963; 7'd58: v = 17'd55578; 7'd59: v = 17'd56175;
      7'd60: v = 17'd56756; 7'd61: v = 17'd57319; 7'd62: v = 17'd57865;
      7'd63: v = 17'd58393; 7'd64: v = 17'd58903; 7'd65: v = 17'd59396;
      7'd66: v = 17'd59870; 7'd67: v = 17'd60326; 7'd68: v = 17'd60764;
      7'd69: v = 17'd61183; 7'd70: v = 17'd61584; 7'd71: v = 17'd61966;
      7'd72: v = 17'd62328; 7'd73: v = 17'd62672; 7'd74: v = 17'd62997;
      7'd75: v = 17'd63303; 7'd76: v = 17'd63589; 7'd77: v = 17'd63856;
      7'd78: v = 17'd64104; 7'd79: v = 17'd64332; 7'd80: v = 17'd64540;
      7'd81: v = 17'd64729; 7'd82: v = 17'd64898; 7'd83: v = 17'd65048;
      7'd84: v = 17'd65177; 7'd85: v = 17'd65287; 7'd86: v = 17'd65376;
      7'd87: v = 17'd65446; 7'd88: v = 17'd65496; 7'd89: v = 17'd65526;
      7'd90: v = 17'd65536;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/led_status_pattern_pwm.sv]
// Pipeline: an accepted input beat passes through the s1, s2 and output registers to its result beat.
// Throughput: one beat per cycle; the three stages (state update, sine
// table lookup, duty multiply) move together and hold only while a
// result sits in the output register under out_stall.
// Reset: synchronous, active-low rst_n; clears pattern state and the pipeline
// and loads the configuration registers with their default values.
module led_status_pattern_pwm #(
  parameter int ELAPSED_WIDTH  = 20,
  parameter int SINE_FRAC_BITS = 15
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_mode,
  input  logic        in_charger_flag,
  input  logic        in_net_light,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_red_duty,
  output logic [15:0] out_green_duty,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  lsp_pkg::cfg_t    cfg;
  lsp_pkg::stage1_t s1;
  logic             adv;

  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  lsp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg_ready (cfg_ready),
    .cfg       (cfg)
  );

  lsp_state #(
    .ELAPSED_WIDTH (ELAPSED_WIDTH)
  ) u_state (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .in_valid        (in_valid),
    .in_mode         (in_mode),
    .in_charger_flag (in_charger_flag),
    .in_net_light    (in_net_light),
    .cfg             (cfg),
    .s1              (s1)
  );

  lsp_shape #(
    .SINE_FRAC_BITS (SINE_FRAC_BITS)
  ) u_shape (
    .clk            (clk),
    .rst_n          (rst_n),
    .adv            (adv),
    .s1             (s1),
    .out_valid      (out_valid),
    .out_red_duty   (out_red_duty),
    .out_green_duty (out_green_duty)
  );

endmodule

[rtl/lsp_cfg.sv]
module lsp_cfg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_valid,
  input  logic [2:0]      cfg_index,
  input  logic [15:0]     cfg_data,
  output logic            cfg_ready,
  output lsp_pkg::cfg_t   cfg
);

  lsp_pkg::cfg_t cfg_r;
  lsp_pkg::cfg_reg_t sel;

  assign sel       = lsp_pkg::cfg_reg_t'(cfg_index);
  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.red_charging_duty   <= 16'd700;
      cfg_r.red_battery_duty    <= 16'd100;
      cfg_r.green_charging_duty <= 16'd700;
      cfg_r.green_battery_duty  <= 16'd100;
      cfg_r.pulse_on_ms         <= 16'd200;
      cfg_r.pulse_off_ms        <= 16'd200;
      cfg_r.pause_ms            <= 16'd1000;
      cfg_r.tick_ms             <= 8'd10;
    end else if (cfg_valid) begin
      unique case (sel)
        lsp_pkg::REG_RED_CHARGING:   cfg_r.red_charging_duty   <= cfg_data;
        lsp_pkg::REG_RED_BATTERY:    cfg_r.red_battery_duty    <= cfg_data;
        lsp_pkg::REG_GREEN_CHARGING: cfg_r.green_charging_duty <= cfg_data;
        lsp_pkg::REG_GREEN_BATTERY:  cfg_r.green_battery_duty  <= cfg_data;
        lsp_pkg::REG_PULSE_ON:       cfg_r.pulse_on_ms         <= cfg_data;
        lsp_pkg::REG_PULSE_OFF:      cfg_r.pulse_off_ms        <= cfg_data;
        lsp_pkg::REG_PAUSE:          cfg_r.pause_ms            <= cfg_data;
        lsp_pkg::REG_TICK:           cfg_r.tick_ms             <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

[rtl/lsp_state.sv]
module lsp_state #(
  parameter int ELAPSED_WIDTH = 20
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [2:0]        in_mode,
  input  logic              in_charger_flag,
  input  logic              in_net_light,
  input  lsp_pkg::cfg_t     cfg,
  output lsp_pkg::stage1_t  s1
);

  logic [2:0]               pulse_index_r, pulse_index_nxt;
  logic                     lamp_lit_r, lamp_lit_nxt;
  logic [ELAPSED_WIDTH-1:0] elapsed_r, elapsed_nxt, elapsed_mid;
  logic [ELAPSED_WIDTH:0]   elapsed_sum;
  logic [8:0]               phase_r, phase_nxt, deg;
  logic                     fire, is_blink, is_sine;
  logic [15:0]              red_full, green_full;
  lsp_pkg::stage1_t         s1_r, s1_nxt;

  assign fire     = in_valid && adv;
  assign is_blink = (in_mode >= lsp_pkg::MODE_BLINK_MIN) && (in_mode <= lsp_pkg::MODE_BLINK_MAX);
  assign is_sine  = (in_mode == lsp_pkg::MODE_SINE_FAST) || (in_mode == lsp_pkg::MODE_SINE_SLOW);
  assign red_full   = in_charger_flag ? cfg.red_battery_duty : cfg.red_charging_duty;
  assign green_full = in_charger_flag ? cfg.green_battery_duty : cfg.green_charging_duty;

  always_comb begin
    pulse_index_nxt = pulse_index_r;
    lamp_lit_nxt    = lamp_lit_r;
    elapsed_mid     = elapsed_r;
    if (in_mode >= pulse_index_r) begin
      if (lamp_lit_r) begin
        if (elapsed_r >= ELAPSED_WIDTH'(cfg.pulse_on_ms)) begin
          elapsed_mid     = '0;
          lamp_lit_nxt    = 1'b0;
          pulse_index_nxt = pulse_index_r + 3'd1;
        end
      end else if (elapsed_r >= ELAPSED_WIDTH'(cfg.pulse_off_ms)) begin
        elapsed_mid  = '0;
        lamp_lit_nxt = 1'b1;
      end
    end else if (elapsed_r >= ELAPSED_WIDTH'(cfg.pause_ms)) begin
      elapsed_mid     = '0;
      pulse_index_nxt = 3'd1;
      lamp_lit_nxt    = 1'b1;
    end
    elapsed_sum = {1'b0, elapsed_mid} + (ELAPSED_WIDTH + 1)'(cfg.tick_ms);
    elapsed_nxt = elapsed_sum[ELAPSED_WIDTH] ? '1 : elapsed_sum[ELAPSED_WIDTH-1:0];
  end

  always_comb begin
    if (phase_r >= lsp_pkg::PHASE_LAST) begin
      phase_nxt = '0;
    end else begin
      phase_nxt = phase_r + ((in_mode == lsp_pkg::MODE_SINE_FAST) ?
                             lsp_pkg::STEP_FAST : lsp_pkg::STEP_SLOW);
    end
    deg = (phase_nxt >= lsp_pkg::PHASE_TURN) ? phase_nxt - lsp_pkg::PHASE_TURN : phase_nxt;
  end

  always_comb begin
    s1_nxt.valid     = in_valid;
    s1_nxt.is_sine   = is_sine;
    s1_nxt.red_val   = (is_blink && lamp_lit_nxt) ? red_full : '0;
    s1_nxt.green_val = in_net_light ? green_full : '0;
    s1_nxt.half      = red_full[15:1];
    s1_nxt.deg       = deg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_index_r <= '0;
      lamp_lit_r    <= 1'b0;
      elapsed_r     <= '0;
      phase_r       <= '0;
    end else if (fire) begin
      if (is_blink) begin
        pulse_index_r <= pulse_index_nxt;
        lamp_lit_r    <= lamp_lit_nxt;
        elapsed_r     <= elapsed_nxt;
      end
      if (is_sine) begin
        phase_r <= phase_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else if (adv) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1 = s1_r;

endmodule

[rtl/lsp_shape.sv]
module lsp_shape #(
  parameter int SINE_FRAC_BITS = 15
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  lsp_pkg::stage1_t  s1,
  output logic              out_valid,
  output logic [15:0]       out_red_duty,
  output logic [15:0]       out_green_duty
);

  localparam int FW = SINE_FRAC_BITS + 2;
  localparam int PW = 15 + FW;

  logic [6:0]          idx;
  logic                neg;
  logic [16:0]         mag;
  logic [17:0]         scaled, rounded;
  logic [FW-1:0]       unit, r, frac_nxt;
  logic [PW-1:0]       prod;
  logic [PW-1:0]       prod_sh;

  logic                s2_valid_r, s2_sine_r;
  logic [15:0]         s2_red_r, s2_green_r;
  logic [14:0]         s2_half_r;
  logic [FW-1:0]       s2_frac_r;

  logic                out_valid_r;
  logic [15:0]         out_red_r, out_red_nxt, out_green_r;

  // quarter-wave fold
  always_comb begin
    priority if (s1.deg <= lsp_pkg::DEG_90) begin
      idx = s1.deg[6:0];
      neg = 1'b0;
    end else if (s1.deg <= lsp_pkg::DEG_180) begin
      idx = 7'(lsp_pkg::DEG_180 - s1.deg);
      neg = 1'b0;
    end else if (s1.deg <= lsp_pkg::DEG_270) begin
      idx = 7'(s1.deg - lsp_pkg::DEG_180);
      neg = 1'b1;
    end else begin
      idx = 7'(lsp_pkg::PHASE_TURN - s1.deg);
      neg = 1'b1;
    end
  end

  always_comb begin
    mag      = lsp_pkg::quarter_sine(idx);
    scaled   = {mag, 1'b0} >> (lsp_pkg::TABLE_FRAC - SINE_FRAC_BITS);
    rounded  = (scaled + 18'd1) >> 1;
    r        = FW'(rounded);
    unit     = FW'(1) << SINE_FRAC_BITS;
    frac_nxt = neg ? unit - r : unit + r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r <= s1.valid;
      s2_sine_r  <= s1.is_sine;
      s2_red_r   <= s1.red_val;
      s2_green_r <= s1.green_val;
      s2_half_r  <= s1.half;
      s2_frac_r  <= frac_nxt;
    end
  end

  always_comb begin
    prod        = PW'(s2_half_r) * PW'(s2_frac_r);
    prod_sh     = prod >> SINE_FRAC_BITS;
    out_red_nxt = s2_sine_r ? prod_sh[15:0] : s2_red_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_valid_r;
      out_red_r   <= out_red_nxt;
      out_green_r <= s2_green_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red_duty   = out_red_r;
  assign out_green_duty = out_green_r;

endmodule

[rtl/lsp_checker.sv]
module lsp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [2:0]  in_mode,
  input logic        in_net_light,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_red_duty,
  input logic [15:0] out_green_duty,
  input logic        cfg_ready
);

  // held result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red_duty) && $stable(out_green_duty))
    else $error("result beat changed under stall");

  // input only backs up when the output register is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat right after reset");

  // dark sleep beat comes out as zeros once it has passed the s1, s2 and output registers
  a_sleep_dark: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_mode == lsp_pkg::MODE_SLEEP && !in_net_light)
      ##1 !out_stall ##1 !out_stall
    |=> out_valid && out_red_duty == 16'd0 && out_green_duty == 16'd0)
    else $error("sleep beat result not zero");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("config port not ready");

endmodule

bind led_status_pattern_pwm lsp_checker u_lsp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_mode        (in_mode),
  .in_net_light   (in_net_light),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_red_duty   (out_red_duty),
  .out_green_duty (out_green_duty),
  .cfg_ready      (cfg_ready)
);
